@@ src/sotg_pkg.sv @@
// ----------------------------------------------------------------------------
// sotg_pkg: shared types and constants of the single-object track gate
// Holds item kinds, register indexes, state codes and fixed constants.
// ----------------------------------------------------------------------------
package sotg_pkg;

  typedef enum logic [1:0] {
    KIND_DETECT = 2'd0,
    KIND_UPDATE = 2'd1,
    KIND_FRAME  = 2'd2,
    KIND_TICK   = 2'd3
  } kind_t;

  localparam logic [2:0] REG_START_X   = 3'd0;
  localparam logic [2:0] REG_START_Y   = 3'd1;
  localparam logic [2:0] REG_START_HUE = 3'd2;
  localparam logic [2:0] REG_START_SZ  = 3'd3;
  localparam logic [2:0] REG_OCCLUDE   = 3'd4;
  localparam logic [2:0] REG_LOST      = 3'd5;
  localparam logic [2:0] REG_ACQ_TO    = 3'd6;
  localparam logic [2:0] REG_ACQ_CNT   = 3'd7;

  localparam logic [2:0] CODE_OCCLUDED = 3'd0;
  localparam logic [2:0] CODE_STILL    = 3'd1;
  localparam logic [2:0] CODE_MOVING   = 3'd2;
  localparam logic [2:0] CODE_GONE     = 3'd3;
  localparam logic [2:0] CODE_OTHER    = 3'd4;

  localparam int HUE_TOL       = 5;
  localparam int DECAY_NUM     = 253;
  // Squared travel magnitude above which the object counts as moving (Q8 squared).
  localparam int MOTION_LIMIT2 = 400 * 65536;

  // Operations of the shared arithmetic unit.
  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_ADD = 2'd1,
    OP_SUB = 2'd2
  } alu_op_t;

endpackage

@@ src/sotg_alu.sv @@
// ----------------------------------------------------------------------------
// sotg_alu: shared arithmetic unit
// One signed multiply, add or subtract per cycle, result registered.
// ----------------------------------------------------------------------------
module sotg_alu #(
  parameter int AW = 24
) (
  input  logic                   clk,
  input  sotg_pkg::alu_op_t      op,
  input  logic signed [2*AW-1:0] a,
  input  logic signed [2*AW-1:0] b,
  output logic signed [2*AW-1:0] y_r
);
  logic signed [AW-1:0]   ma, mb;
  logic signed [2*AW-1:0] prod, y_nxt;

  // The multiplier only sees the low operand halves, taken as signed values.
  assign ma   = a[AW-1:0];
  assign mb   = b[AW-1:0];
  assign prod = ma * mb;

  always_comb begin
    case (op)
      sotg_pkg::OP_MUL: y_nxt = prod;
      sotg_pkg::OP_ADD: y_nxt = a + b;
      sotg_pkg::OP_SUB: y_nxt = a - b;
      default:          y_nxt = a;
    endcase
  end

  always_ff @(posedge clk) begin
    y_r <= y_nxt;
  end
endmodule

@@ src/single_object_track_gate.sv @@
// Sequencing: detect, frame end and tick items go from acceptance to S_FIN,
// which registers the result item; an update item passes S_M1 to S_M4 first,
// or only S_M1 when gone or not yet acquired, as the multiplier sequence is skipped.
// One item at a time, the next accepted only back in S_IDLE; a result item
// waiting for out_tready holds off the next item.
// Reset: synchronous active-low rst_n restores registers to defaults and the
// track state to its start values.
// ----------------------------------------------------------------------------
// single_object_track_gate: top level
// Gates detections, tracks one object and reports its state per item.
// ----------------------------------------------------------------------------
module single_object_track_gate #(
  parameter int COORD_BITS = 12,
  parameter int TICK_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: pos_x, pos_y, hue[7:0], obj_size, obj_height[15:0] from bit 0 up
  input  logic [((3*COORD_BITS+24+7)/8)*8-1:0] in_tdata,
  // tuser: kind[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: recognized, contained, state_code[2:0], alive, moving, vel_x,
  // vel_y, height_rate[16:0], cur_hue[7:0], cur_x, cur_y from bit 0 up
  output logic [((4*COORD_BITS+34+7)/8)*8-1:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  localparam int CB = COORD_BITS;
  localparam int VB = CB + 1;
  localparam int TB = CB + 10;
  localparam int AW = TB + 1;
  localparam int YW = 2 * AW;
  localparam int OW = ((4*CB+34+7)/8)*8;

  typedef enum logic [2:0] {
    S_IDLE, S_M1, S_M2, S_M3, S_M4, S_FIN
  } st_t;

  st_t st_r;
  logic [1:0] kind_r;
  logic [CB-1:0] px_r, py_r, sz_r;
  logic [7:0] hu_r;
  logic signed [15:0] ht_r;

  logic [15:0] occ_r, lost_r, acqto_r;
  logic [4:0] acqc_r;

  logic [CB-1:0] ox_r, oy_r, size_r;
  logic [7:0] mhue_r;
  logic signed [VB-1:0] sx_r, sy_r;
  logic signed [15:0] lh_r;
  logic signed [16:0] hs_r;
  logic signed [TB-1:0] tx_r, ty_r;
  logic vis_r, occl_r, gone_r, mov_r, acq_r, trk_r;
  logic [4:0] mc_r;
  logic [TICK_BITS-1:0] idle_r;

  logic signed [YW-1:0] t1_r;

  logic ovalid_r;
  logic [OW-1:0] odata_r;

  sotg_pkg::alu_op_t op;
  logic signed [YW-1:0] alu_a, alu_b, alu_y;

  sotg_alu #(.AW(AW)) u_alu (.clk(clk), .op(op), .a(alu_a), .b(alu_b), .y_r(alu_y));

  assign in_tready  = (st_r == S_IDLE) && !(ovalid_r && !out_tready);
  assign cfg_ready  = (st_r == S_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

  // Window and hue gate, combinational on narrow values.
  logic signed [CB+4:0] wx, wy, ax, ay, dx, dy;
  logic signed [9:0] dh;
  logic win, hue_ok;
  always_comb begin
    ax = (CB+5)'(sx_r) * (CB+5)'(3);
    ay = (CB+5)'(sy_r) * (CB+5)'(3);
    if (ax < 0) ax = -ax;
    if (ay < 0) ay = -ay;
    wx = (CB+5)'(size_r) * (CB+5)'(3) + ax;
    wy = (CB+5)'(size_r) * (CB+5)'(3) + ay;
    dx = (CB+5)'(px_r) - (CB+5)'(ox_r);
    dy = (CB+5)'(py_r) - (CB+5)'(oy_r);
    win = (dx > -wx) && (dx < wx) && (dy > -wy) && (dy < wy);
    dh = 10'(hu_r) - 10'(mhue_r);
    hue_ok = (dh > -10'(sotg_pkg::HUE_TOL)) && (dh < 10'(sotg_pkg::HUE_TOL));
  end

  // Travel step operands: decay product via shared unit, then floor, add and saturate.
  logic signed [TB-1:0] ddx, ddy;
  assign ddx = TB'(signed'({1'b0, ox_r})) - TB'(signed'({1'b0, px_r}));
  assign ddy = TB'(signed'({1'b0, oy_r})) - TB'(signed'({1'b0, py_r}));

  function automatic logic signed [TB-1:0] tstep(input logic signed [YW-1:0] p,
                                                 input logic signed [TB-1:0] d);
    logic signed [YW-1:0] q;
    logic signed [YW-1:0] lim;
    begin
      q = (p >>> 8) + (YW'(d) <<< 8);
      lim = YW'(1) <<< (TB-1);
      if (q > lim - 1) q = lim - 1;
      if (q < -lim) q = -lim;
      tstep = TB'(q);
    end
  endfunction

  always_comb begin
    op = sotg_pkg::OP_MUL;
    alu_a = YW'(tx_r);
    alu_b = YW'(sotg_pkg::DECAY_NUM);
    case (st_r)
      S_M1: begin alu_a = YW'(ty_r); end
      S_M2: begin alu_a = YW'(tx_r); alu_b = YW'(tx_r); end
      S_M3: begin alu_a = YW'(ty_r); alu_b = YW'(ty_r); end
      S_M4: begin op = sotg_pkg::OP_ADD; alu_a = t1_r; alu_b = alu_y; end
      default: ;
    endcase
  end

  // One bit wider than the count so that a count of 31 plus one still compares.
  logic [5:0] n6;
  assign n6 = {1'b0, mc_r} + 6'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ovalid_r <= 1'b0;
      occ_r <= 16'd1000; lost_r <= 16'd1500; acqto_r <= 16'd3000; acqc_r <= 5'd20;
      ox_r <= '0; oy_r <= '0; mhue_r <= '0; size_r <= CB'(16);
      sx_r <= '0; sy_r <= '0; lh_r <= '0; hs_r <= '0; tx_r <= '0; ty_r <= '0;
      vis_r <= 1'b0; occl_r <= 1'b1; gone_r <= 1'b0; mov_r <= 1'b0;
      acq_r <= 1'b0; trk_r <= 1'b0; mc_r <= '0; idle_r <= '0;
    end else begin
      if (ovalid_r && out_tready) ovalid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sotg_pkg::REG_START_X:   ox_r <= cfg_data[CB-1:0];
          sotg_pkg::REG_START_Y:   oy_r <= cfg_data[CB-1:0];
          sotg_pkg::REG_START_HUE: mhue_r <= cfg_data[7:0];
          sotg_pkg::REG_START_SZ:  size_r <= cfg_data[CB-1:0];
          sotg_pkg::REG_OCCLUDE:   occ_r <= cfg_data[15:0];
          sotg_pkg::REG_LOST:      lost_r <= cfg_data[15:0];
          sotg_pkg::REG_ACQ_TO:    acqto_r <= cfg_data[15:0];
          sotg_pkg::REG_ACQ_CNT:   acqc_r <= cfg_data[4:0];
          default: ;
        endcase
      end
      case (st_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            kind_r <= in_tuser;
            px_r <= in_tdata[CB-1:0];
            py_r <= in_tdata[2*CB-1:CB];
            hu_r <= in_tdata[2*CB+7:2*CB];
            sz_r <= in_tdata[3*CB+7:2*CB+8];
            ht_r <= in_tdata[3*CB+23:3*CB+8];
            if (in_tuser == sotg_pkg::KIND_UPDATE) st_r <= S_M1;
            else st_r <= S_FIN;
          end
        end
        S_M1: begin
          if (gone_r || !acq_r) st_r <= S_FIN;
          else begin tx_r <= tstep(alu_y, ddx); st_r <= S_M2; end
        end
        S_M2: begin ty_r <= tstep(alu_y, ddy); st_r <= S_M3; end
        S_M3: begin t1_r <= alu_y; st_r <= S_M4; end
        S_M4: st_r <= S_FIN;
        S_FIN: begin
          logic recd, trk2, gone2, occ2, vis2, mov2;
          logic [2:0] code;
          logic [OW-1:0] od;
          recd = 1'b0; trk2 = trk_r; gone2 = gone_r; occ2 = occl_r;
          vis2 = vis_r; mov2 = mov_r;
          case (sotg_pkg::kind_t'(kind_r))
            sotg_pkg::KIND_DETECT: begin
              if (!gone_r && !trk_r && (occl_r || win) && hue_ok) begin
                recd = 1'b1; trk2 = 1'b1;
                if (!acq_r) begin
                  if (n6 > {1'b0, acqc_r}) begin acq_r <= 1'b1; mc_r <= '0; end
                  else mc_r <= n6[4:0];
                end
              end
              if (32'(idle_r) > 32'(acqto_r) &&
                  !(acq_r || (recd && n6 > {1'b0, acqc_r})))
                gone2 = 1'b1;
            end
            sotg_pkg::KIND_UPDATE: begin
              if (!gone_r) begin
                if (!acq_r) begin
                  vis2 = 1'b0; mov2 = 1'b0; occ2 = 1'b1;
                end else begin
                  vis2 = 1'b1; occ2 = 1'b0;
                  mhue_r <= hu_r;
                  sx_r <= VB'(signed'({1'b0, px_r})) - VB'(signed'({1'b0, ox_r}));
                  sy_r <= VB'(signed'({1'b0, py_r})) - VB'(signed'({1'b0, oy_r}));
                  hs_r <= 17'(ht_r) - 17'(lh_r);
                  ox_r <= px_r; oy_r <= py_r; size_r <= sz_r; lh_r <= ht_r;
                  if (alu_y > YW'(sotg_pkg::MOTION_LIMIT2)) begin
                    mov2 = 1'b1; tx_r <= '0; ty_r <= '0;
                  end else mov2 = 1'b0;
                end
              end
            end
            sotg_pkg::KIND_FRAME: begin
              if (trk_r) idle_r <= '0;
              else if (32'(idle_r) > 32'(occ_r) && !occl_r) begin
                occ2 = 1'b1; vis2 = 1'b0;
              end else if (32'(idle_r) > 32'(lost_r) && !gone_r) gone2 = 1'b1;
              trk2 = 1'b0;
            end
            default: if (idle_r != '1) idle_r <= idle_r + 1'b1;
          endcase
          trk_r <= trk2; gone_r <= gone2; occl_r <= occ2; vis_r <= vis2;
          mov_r <= mov2;
          if (vis2 && !gone2 && !occ2)
            code = mov2 ? sotg_pkg::CODE_MOVING : sotg_pkg::CODE_STILL;
          else if (occ2 && !gone2) code = sotg_pkg::CODE_OCCLUDED;
          else if (gone2) code = sotg_pkg::CODE_GONE;
          else code = sotg_pkg::CODE_OTHER;
          od = '0;
          od[0] = recd;
          od[1] = (kind_r == sotg_pkg::KIND_DETECT) && trk2 && win && hue_ok;
          od[4:2] = code;
          od[5] = !gone2;
          od[6] = mov2;
          if (kind_r == sotg_pkg::KIND_UPDATE && !gone_r && acq_r) begin
            od[7+:VB] = VB'(signed'({1'b0, px_r})) - VB'(signed'({1'b0, ox_r}));
            od[7+VB+:VB] = VB'(signed'({1'b0, py_r})) - VB'(signed'({1'b0, oy_r}));
            od[7+2*VB+:17] = 17'(ht_r) - 17'(lh_r);
            od[24+2*VB+:8] = hu_r;
            od[32+2*VB+:CB] = px_r;
            od[32+2*VB+CB+:CB] = py_r;
          end else begin
            od[7+:VB] = sx_r;
            od[7+VB+:VB] = sy_r;
            od[7+2*VB+:17] = hs_r;
            od[24+2*VB+:8] = mhue_r;
            od[32+2*VB+:CB] = ox_r;
            od[32+2*VB+CB+:CB] = oy_r;
          end
          odata_r <= od;
          ovalid_r <= 1'b1;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

@@ src/sotg_checker.sv @@
// ----------------------------------------------------------------------------
// sotg_checker: port-level checks of the track gate
// Watches handshakes and result fields over time.
// ----------------------------------------------------------------------------
module sotg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata
);
  // A result item is held until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped while stalled");

  // Alive is the inverse of the gone state code.
  a_alive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[5] == (out_tdata[4:2] != sotg_pkg::CODE_GONE)))
    else $error("alive disagrees with state code");

  // An item cannot be accepted while a stalled result waits.
  a_noacc: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("accepted over a stalled result");

  // The state code stays within its defined range.
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[4:2] <= sotg_pkg::CODE_OTHER)
    else $error("state code out of range");

  // Every accepted item is followed by a result item.
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> ##[1:8] out_tvalid)
    else $error("no result item after an accepted item");
endmodule

bind single_object_track_gate sotg_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata[71:0])
);
